[rtl/deque_with_wait_statistics_defines.svh]
// ----------------------------------------------------------------------------
// Deque with wait statistics: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_WAIT_STATISTICS_DEFINES_SVH
`define DEQUE_WITH_WAIT_STATISTICS_DEFINES_SVH

// Same-cycle implication.
`define DQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/dqws_pkg.sv]
// ----------------------------------------------------------------------------
// Deque with wait statistics: package
// Sizes, request and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package dqws_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int SLOT_BITS   = $clog2(QUEUE_DEPTH);
  localparam int COUNT_BITS  = SLOT_BITS + 1;
  localparam int HANDLE_BITS = 16;
  localparam int TIME_BITS   = 48;
  localparam int STAT_BITS   = 64;
  localparam int ENTRY_BITS  = HANDLE_BITS + TIME_BITS;

  typedef enum logic [1:0] {
    OP_PUSH_HEAD = 2'd0,
    OP_PUSH_TAIL = 2'd1,
    OP_POP_HEAD  = 2'd2,
    OP_STATS     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_COMMIT
  } state_t;

endpackage

`default_nettype wire

[rtl/deque_with_wait_statistics.sv]
// Each request passes in turn through the ring memory read of the head slot,
// the wait subtraction and the commit; a new request is taken only once the
// previous one has committed.
// A full output register stalls the commit step; no new request is taken meanwhile.
// Reset (rst, synchronous): pointers, count and all statistics accumulators clear to zero;
// ring memory contents are left undefined, no clearing pass.
// ----------------------------------------------------------------------------
// Deque with wait statistics
// Ring-buffer deque of handles with timestamps, wait times and running counters.
// ----------------------------------------------------------------------------
`default_nettype none

`include "deque_with_wait_statistics_defines.svh"

module deque_with_wait_statistics
  import dqws_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             op,
  input  wire logic [HANDLE_BITS-1:0] item,
  input  wire logic [TIME_BITS-1:0]   now,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  status,
  output logic [HANDLE_BITS-1:0]      item_out,
  output logic [TIME_BITS-1:0]        wait_time,
  output logic [COUNT_BITS-1:0]       occupancy,
  output logic [STAT_BITS-1:0]        occupancy_sum,
  output logic [STAT_BITS-1:0]        enqueued_count,
  output logic [STAT_BITS-1:0]        dequeued_count,
  output logic [STAT_BITS-1:0]        wait_sum
);

  state_t state, state_next;

  // Request held while it is in flight
  op_t                  req_op;
  logic [HANDLE_BITS-1:0] req_item;
  logic [TIME_BITS-1:0]   req_now;

  // Ring memory: {handle, stamp}
  logic [ENTRY_BITS-1:0] mem [QUEUE_DEPTH];
  logic [ENTRY_BITS-1:0] rd_entry;
  logic                  mem_re;
  logic                  mem_we;
  logic [SLOT_BITS-1:0]  mem_wa;
  logic [ENTRY_BITS-1:0] mem_wd;

  logic [SLOT_BITS-1:0]  head_index;
  logic [COUNT_BITS-1:0] entry_count;
  logic [STAT_BITS-1:0]  size_acc;
  logic [STAT_BITS-1:0]  push_total;
  logic [STAT_BITS-1:0]  pop_total;
  logic [STAT_BITS-1:0]  wait_acc;
  logic [TIME_BITS-1:0]  wait_reg;

  logic commit;
  logic is_push;
  logic is_pop;
  logic q_full;
  logic q_empty;
  logic push_ok;
  logic pop_ok;

  assign is_push = (req_op inside {OP_PUSH_HEAD, OP_PUSH_TAIL});
  assign is_pop  = (req_op == OP_POP_HEAD);
  assign q_full  = (entry_count == COUNT_BITS'(QUEUE_DEPTH));
  assign q_empty = (entry_count == '0);
  assign push_ok = is_push && !q_full;
  assign pop_ok  = is_pop && !q_empty;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mem_re     = 1'b0;
    commit     = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mem_re     = 1'b1;
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          commit     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Write port: new entry goes before the head or after the tail
  always_comb begin
    mem_we = commit && push_ok;
    mem_wd = {req_item, req_now};
    if (req_op == OP_PUSH_HEAD) begin
      mem_wa = head_index - SLOT_BITS'(1);
    end else begin
      mem_wa = head_index + entry_count[SLOT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_entry <= mem[head_index];
    end
  end

  // Capture request; compute the wait of the head entry
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_op   <= op_t'(op);
      req_item <= item;
      req_now  <= now;
    end
    if (state == S_CALC) begin
      wait_reg <= req_now - rd_entry[TIME_BITS-1:0];
    end
  end

  // Queue state and statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      head_index  <= '0;
      entry_count <= '0;
      size_acc    <= '0;
      push_total  <= '0;
      pop_total   <= '0;
      wait_acc    <= '0;
    end else if (commit) begin
      if (push_ok) begin
        if (req_op == OP_PUSH_HEAD) begin
          head_index <= head_index - SLOT_BITS'(1);
        end
        entry_count <= entry_count + COUNT_BITS'(1);
        size_acc    <= size_acc + STAT_BITS'(entry_count);
        push_total  <= push_total + STAT_BITS'(1);
      end else if (pop_ok) begin
        head_index  <= head_index + SLOT_BITS'(1);
        entry_count <= entry_count - COUNT_BITS'(1);
        pop_total   <= pop_total + STAT_BITS'(1);
        wait_acc    <= wait_acc + STAT_BITS'(wait_reg);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status         <= ST_DONE;
      item_out       <= '0;
      wait_time      <= '0;
      occupancy      <= entry_count;
      occupancy_sum  <= size_acc;
      enqueued_count <= push_total;
      dequeued_count <= pop_total;
      wait_sum       <= wait_acc;
      if (is_push) begin
        if (q_full) begin
          status <= ST_FULL;
        end else begin
          occupancy      <= entry_count + COUNT_BITS'(1);
          occupancy_sum  <= size_acc + STAT_BITS'(entry_count);
          enqueued_count <= push_total + STAT_BITS'(1);
        end
      end else if (is_pop) begin
        if (q_empty) begin
          status <= ST_EMPTY;
        end else begin
          item_out       <= rd_entry[ENTRY_BITS-1:TIME_BITS];
          wait_time      <= wait_reg;
          occupancy      <= entry_count - COUNT_BITS'(1);
          dequeued_count <= pop_total + STAT_BITS'(1);
          wait_sum       <= wait_acc + STAT_BITS'(wait_reg);
        end
      end
    end
  end

  // Checks
  `DQ_ASSERT_NOW(a_count_bound, 1'b1, entry_count <= COUNT_BITS'(QUEUE_DEPTH),
                 "entry count above queue depth")
  `DQ_ASSERT_NEXT(a_accept_to_calc, in_valid && in_ready, state == S_CALC,
                  "accepted request did not start its memory read")
  `DQ_ASSERT_NEXT(a_push_count, commit && push_ok,
                  entry_count == $past(entry_count) + COUNT_BITS'(1),
                  "successful push did not grow the queue")
  `DQ_ASSERT_NEXT(a_pop_total, commit && pop_ok,
                  pop_total == $past(pop_total) + STAT_BITS'(1),
                  "successful pop did not advance the pop total")
  `DQ_ASSERT_NOW(a_commit_slot, commit, !out_valid || out_ready,
                 "result committed over an unread result")

endmodule

`default_nettype wire
